// ===== hdl/wifi_channel_selector_assert.svh =====
// Assertion macros for the channel selector
`ifndef WIFI_CHANNEL_SELECTOR_ASSERT_SVH
`define WIFI_CHANNEL_SELECTOR_ASSERT_SVH

`ifndef SYNTHESIS
`define WCS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("wcs assertion failed");
`define WCS_ASSERT_NR(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("wcs assertion failed");
`else
`define WCS_ASSERT(lbl, clk, rst_n, prop)
`define WCS_ASSERT_NR(lbl, clk, prop)
`endif

`endif

// ===== hdl/wcs_pkg.sv =====
// Types and constants shared by the channel selector modules
`timescale 1ns / 1ps

package wcs_pkg;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_REC   = 2'd1;
	localparam logic [1:0] CMD_PICK  = 2'd2;
	localparam logic [1:0] CMD_CHK   = 2'd3;

	localparam logic signed [7:0] LEVEL_FLOOR  = -8'sd128;
	localparam logic [9:0]        WEIGHT_START = 10'd1000;

	typedef logic [3:0] ch_t;

	typedef struct packed {
		logic [1:0]        command;
		ch_t               scan_channel;
		logic signed [7:0] signal_level;
	} item_t;

	typedef struct packed {
		ch_t        best_channel;
		logic       channel_free;
		logic [9:0] min_weight;
		logic       bad_channel;
	} result_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic step;
		logic walk_done;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_walk;
		logic walk_last;
	} ctrl_sts_t;

endpackage

// ===== hdl/wcs_ctrl.sv =====
// Controller state machine of the channel selector
`timescale 1ns / 1ps

module wcs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  wcs_pkg::ctrl_sts_t sts,
	output wcs_pkg::ctrl_cmd_t cmd
);
	import wcs_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_WALK = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.need_walk) begin
					state_d = S_WALK;
				end else begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_WALK: begin
				cmd.step = 1'b1;
				if (sts.walk_last) begin
					cmd.walk_done = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== hdl/wcs_dp.sv =====
// Datapath of the channel selector: table, window, walk registers, result
`timescale 1ns / 1ps

module wcs_dp #(
	parameter int NUM_CHANNELS = 13
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wcs_pkg::item_t     item,
	input  wcs_pkg::ctrl_cmd_t cmd,
	output wcs_pkg::ctrl_sts_t sts,
	output wcs_pkg::result_t   result,
	output logic               done
);
	import wcs_pkg::*;

	localparam int IW = $clog2(NUM_CHANNELS);
	localparam int CW = $clog2(NUM_CHANNELS + 4);

	logic [1:0]        cmd_q;
	ch_t               ch_q;
	logic signed [7:0] lv_q;

	logic signed [7:0]     lvl_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] used_q;

	logic [CW-1:0] cnt_q;
	logic [7:0]    win_q [7];
	logic [9:0]    bw_q;
	ch_t           bi_q;
	logic          ff_found_q;
	ch_t           ff_q;
	ch_t           weak_ch_q;
	logic signed [7:0] weak_lv_q;

	result_t res_q;
	result_t res_d;
	logic    done_q;

	logic              is_pick;
	logic              bad;
	logic [IW-1:0]     idx;
	logic              in_tab;
	logic [IW-1:0]     rd_idx;
	logic              rd_used;
	logic signed [7:0] rd_lvl;
	logic signed [7:0] eff;
	logic [7:0]        e_in;
	logic [9:0]        w;
	logic [9:0]        bw_d;
	ch_t               bi_d;
	logic              ff_found_d;
	ch_t               ff_d;
	ch_t               weak_ch_d;
	logic signed [7:0] weak_lv_d;

	assign is_pick = (cmd_q == CMD_PICK);
	assign bad     = ((cmd_q == CMD_REC) || (cmd_q == CMD_CHK)) &&
	                 ((ch_q == 4'd0) || ({1'b0, ch_q} > 5'(NUM_CHANNELS)));
	assign idx     = IW'(ch_q - 4'd1);
	assign in_tab  = (cnt_q < CW'(NUM_CHANNELS));
	assign rd_idx  = cmd.step ? (in_tab ? cnt_q[IW-1:0] : '0) : idx;
	assign rd_used = used_q[rd_idx];
	assign rd_lvl  = lvl_q[rd_idx];
	assign eff     = rd_used ? rd_lvl : LEVEL_FLOOR;
	// level + 128
	assign e_in    = in_tab ? {~eff[7], eff[6:0]} : 8'd0;

	assign w = {2'b00, win_q[3]}
	         + {3'b000, win_q[2][7:1]} + {3'b000, win_q[4][7:1]}
	         + {4'b0000, win_q[1][7:2]} + {4'b0000, win_q[5][7:2]}
	         + {5'b00000, win_q[0][7:3]} + {5'b00000, win_q[6][7:3]};

	assign sts.need_walk = is_pick || ((cmd_q == CMD_CHK) && !bad && rd_used);
	assign sts.walk_last = is_pick ? (cnt_q == CW'(NUM_CHANNELS + 3))
	                               : (cnt_q == CW'(NUM_CHANNELS - 1));

	always_comb begin
		bw_d       = bw_q;
		bi_d       = bi_q;
		ff_found_d = ff_found_q;
		ff_d       = ff_q;
		weak_ch_d  = weak_ch_q;
		weak_lv_d  = weak_lv_q;
		if (is_pick) begin
			// window center holds table entry cnt-4, which is channel cnt-3
			if ((cnt_q >= CW'(4)) && (w < bw_q)) begin
				bw_d = w;
				bi_d = ch_t'(cnt_q - CW'(3));
			end
		end else if (in_tab) begin
			if (!ff_found_q && !rd_used) begin
				ff_found_d = 1'b1;
				ff_d       = ch_t'(cnt_q + CW'(1));
			end
			if (rd_used && (rd_lvl < weak_lv_q)) begin
				weak_ch_d = ch_t'(cnt_q + CW'(1));
				weak_lv_d = rd_lvl;
			end
		end
	end

	always_comb begin
		res_d = '0;
		if (cmd.exec) begin
			if (bad) begin
				res_d.bad_channel = 1'b1;
			end else if (cmd_q == CMD_CHK) begin
				res_d.channel_free = 1'b1;
				res_d.best_channel = ch_q;
			end
		end else if (is_pick) begin
			res_d.best_channel = bi_d;
			res_d.min_weight   = bw_d;
		end else begin
			res_d.best_channel = ff_found_d ? ff_d : weak_ch_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= item.command;
			ch_q  <= item.scan_channel;
			lv_q  <= item.signal_level;
		end
		if (cmd.exec && (cmd_q == CMD_REC) && !bad) begin
			if (!used_q[idx] || (lvl_q[idx] < lv_q)) begin
				lvl_q[idx] <= lv_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cnt_q      <= '0;
			bw_q       <= WEIGHT_START;
			bi_q       <= '0;
			ff_found_q <= 1'b0;
			ff_q       <= '0;
			weak_ch_q  <= '0;
			weak_lv_q  <= '0;
			for (int k = 0; k < 7; k++) begin
				win_q[k] <= '0;
			end
		end else if (cmd.step) begin
			cnt_q      <= cnt_q + CW'(1);
			bw_q       <= bw_d;
			bi_q       <= bi_d;
			ff_found_q <= ff_found_d;
			ff_q       <= ff_d;
			weak_ch_q  <= weak_ch_d;
			weak_lv_q  <= weak_lv_d;
			win_q[0]   <= e_in;
			for (int k = 1; k < 7; k++) begin
				win_q[k] <= win_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec || cmd.walk_done) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.exec || cmd.walk_done;
			if (cmd.exec && (cmd_q == CMD_CLEAR)) begin
				used_q <= '0;
			end else if (cmd.exec && (cmd_q == CMD_REC) && !bad) begin
				used_q[idx] <= 1'b1;
			end
		end
	end

	assign result = res_q;
	assign done   = done_q;

endmodule

// ===== hdl/wifi_channel_selector.sv =====
// Top level of the channel selector: controller plus datapath
`timescale 1ns / 1ps

// Per-channel scan table with clear, record, pick-weakest and check-free
// commands. An item is taken when start is high and busy is low; its result
// is on result for the single cycle in which done is high and must be taken
// then, as the receiver cannot stall the block. A new item may be started in
// the done cycle. Clear, record, a free-channel check of an unused channel
// and any item with a bad channel finish without a walk. A check of a used
// channel walks the table once, one entry per cycle. Pick weakest streams the
// table through a 7-tap neighbour window and one weight adder. Reset clears
// all used flags at once; an unused entry reads as level -128.
module wifi_channel_selector #(
	parameter int NUM_CHANNELS = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  wcs_pkg::item_t   item,
	output logic             done,
	output wcs_pkg::result_t result
);
	import wcs_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	wcs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	wcs_dp #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result),
		.done   (done)
	);

`include "wifi_channel_selector_assert.svh"

	`WCS_ASSERT(a_accept_busy, clk, arst_n, (start && !busy) |=> busy)
	`WCS_ASSERT(a_done_idle, clk, arst_n, done |-> !busy)
	`WCS_ASSERT(a_done_single, clk, arst_n, done |=> !done)
	`WCS_ASSERT_NR(a_rst_quiet, clk, !arst_n |=> !done)

endmodule

// ===== tb/sv/tb_wifi_channel_selector.sv =====
// Self-checking testbench for the channel selector: queued driver, monitor, table predictor
`timescale 1ns / 1ps

module tb_wifi_channel_selector;
	import wcs_pkg::*;

	localparam int NCH = 13;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	item_t   cmd_item = '0;
	logic    busy;
	logic    done;
	result_t choice_out;

	item_t   cmd_q[$];
	result_t choice_q[$];
	int      send_idle_pct = 22;
	int      errors = 0;
	int      queued = 0;

	logic signed [7:0] lvl_tab [NCH];
	logic              used_tab [NCH];

	wifi_channel_selector #(.NUM_CHANNELS(NCH)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (cmd_item),
		.done   (done),
		.result (choice_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_levels();
		int k;
		for (k = 0; k < NCH; k++) begin
			lvl_tab[k] = LEVEL_FLOOR;
			used_tab[k] = 1'b0;
		end
	endfunction

	function automatic int excess(int k);
		if (k < 0 || k >= NCH)
			return 0;
		return int'(lvl_tab[k]) + 128;
	endfunction

	function automatic int weight(int i);
		return excess(i) + (excess(i - 1) >> 1) + (excess(i + 1) >> 1)
			+ (excess(i - 2) >> 2) + (excess(i + 2) >> 2)
			+ (excess(i - 3) >> 3) + (excess(i + 3) >> 3);
	endfunction

	function automatic result_t predict_choice(item_t it);
		result_t r;
		int i, w, bw, bi, idx, first_free, weak_ch, weak_lv;
		r = '0;
		if (it.command == CMD_CLEAR) begin
			clear_levels();
		end else if (it.command == CMD_PICK) begin
			bw = int'(WEIGHT_START);
			bi = 0;
			for (i = 0; i < NCH; i++) begin
				w = weight(i);
				if (w < bw) begin
					bw = w;
					bi = i;
				end
			end
			r.best_channel = 4'(bi + 1);
			r.min_weight = 10'(bw);
		end else if (it.scan_channel < 1 || it.scan_channel > NCH) begin
			r.bad_channel = 1'b1;
		end else begin
			idx = int'(it.scan_channel) - 1;
			if (it.command == CMD_REC) begin
				if (!used_tab[idx] || lvl_tab[idx] < it.signal_level) begin
					used_tab[idx] = 1'b1;
					lvl_tab[idx] = it.signal_level;
				end
			end else if (!used_tab[idx]) begin
				r.channel_free = 1'b1;
				r.best_channel = it.scan_channel;
			end else begin
				first_free = 0;
				weak_ch = 0;
				weak_lv = 0;
				for (i = 0; i < NCH; i++) begin
					if (first_free == 0 && !used_tab[i])
						first_free = i + 1;
					if (used_tab[i] && int'(lvl_tab[i]) < weak_lv) begin
						weak_ch = i + 1;
						weak_lv = int'(lvl_tab[i]);
					end
				end
				r.best_channel = 4'(first_free != 0 ? first_free : weak_ch);
			end
		end
		return r;
	endfunction

	// driver: hold the item while busy, pick the next one once it is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				choice_q.push_back(predict_choice(cmd_item));
			if (!start || !busy) begin
				if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cmd_item <= cmd_q.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// monitor
	always @(posedge clk) begin
		result_t e;
		if (arst_n && done) begin
			if (choice_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, choice_out);
				errors++;
			end else begin
				e = choice_q.pop_front();
				check_field("best_channel", int'(e.best_channel),
					int'(choice_out.best_channel));
				check_field("channel_free", int'(e.channel_free),
					int'(choice_out.channel_free));
				check_field("min_weight", int'(e.min_weight),
					int'(choice_out.min_weight));
				check_field("bad_channel", int'(e.bad_channel),
					int'(choice_out.bad_channel));
			end
		end
	end

	task automatic push(logic [1:0] cmd, int ch, logic signed [7:0] lvl);
		item_t it;
		it.command = cmd;
		it.scan_channel = 4'(ch);
		it.signal_level = lvl;
		cmd_q.push_back(it);
		queued++;
	endtask

	function automatic logic signed [7:0] draw_level(int mode);
		case (mode)
			0: return 8'($urandom_range(255));
			1: return 8'($urandom_range(127));
			2: return 8'h80 | 8'($urandom_range(127));
			3: return $urandom_range(1) ? 8'sd127 : LEVEL_FLOOR;
			default: return 8'($urandom_range(3) * 64);
		endcase
	endfunction

	// optionally clear, fill part or all of the table, revisit a few channels, then query
	task automatic push_scan_round();
		int perm [NCH];
		int j, s, t, n, mode;
		for (j = 0; j < NCH; j++)
			perm[j] = j + 1;
		for (j = NCH - 1; j > 0; j--) begin
			s = $urandom_range(j);
			t = perm[j];
			perm[j] = perm[s];
			perm[s] = t;
		end
		mode = $urandom_range(4);
		n = ($urandom_range(9) < 4) ? NCH : $urandom_range(NCH - 1);
		if ($urandom_range(1))
			push(CMD_CLEAR, $urandom_range(15), 8'($urandom_range(255)));
		for (j = 0; j < n; j++) begin
			push(CMD_REC, perm[j], draw_level(mode));
			if ($urandom_range(9) == 0)
				push(2'($urandom_range(3)), $urandom_range(15), 8'($urandom_range(255)));
		end
		repeat ($urandom_range(3))
			push(CMD_REC, $urandom_range(1, NCH), draw_level(mode));
		repeat ($urandom_range(1, 4)) begin
			if ($urandom_range(1))
				push(CMD_CHK, $urandom_range(1, NCH), 8'($urandom_range(255)));
			else
				push(CMD_PICK, $urandom_range(15), 8'($urandom_range(255)));
		end
	endtask

	task automatic run_random(int count);
		int goal;
		goal = queued + count;
		while (queued < goal)
			push_scan_round();
	endtask

	task automatic drain();
		while (cmd_q.size() != 0 || start)
			@(posedge clk);
		while (choice_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		int k;
		clear_levels();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push(CMD_CHK, 1, 8'sd0);
		push(CMD_PICK, 0, 8'sd0);
		push(CMD_REC, 0, 8'sd5);
		push(CMD_REC, 14, 8'sd5);
		push(CMD_CHK, 15, -8'sd1);
		push(CMD_CHK, 0, 8'sd0);
		push(CMD_REC, 1, 8'sd127);
		push(CMD_REC, 1, LEVEL_FLOOR);
		push(CMD_REC, NCH, LEVEL_FLOOR);
		push(CMD_CHK, 1, 8'sd0);
		push(CMD_PICK, 15, -8'sd1);
		push(CMD_CLEAR, 15, -8'sd1);
		for (k = 1; k <= NCH; k++)
			push(CMD_REC, k, 8'(20 * k - 140));
		push(CMD_CHK, 5, 8'sd0);
		push(CMD_PICK, 0, 8'sd0);

		run_random(340);
		drain();
		send_idle_pct = 75;
		run_random(340);
		drain();
		send_idle_pct = 0;
		run_random(340);
		drain();
		repeat (40) @(posedge clk);

		if (errors == 0)
			$display("wifi_channel_selector regression: pass");
		else
			$display("wifi_channel_selector regression: fail");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("wifi_channel_selector regression: fail");
		$finish;
	end

endmodule
